// ----- sv/client_flow_stats_table_top_assert.svh -----
// Assertion macros for the client flow statistics table.
// Used by the top level only.
`ifndef CLIENT_FLOW_STATS_TABLE_TOP_ASSERT_SVH
`define CLIENT_FLOW_STATS_TABLE_TOP_ASSERT_SVH
// Property that must hold on every clock once out of reset.
`define CFST_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Implication checked on the next clock.
`define CFST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- sv/cfst_pkg.sv -----
// Shared types and constants for the client flow statistics table.
// No dependencies.
package cfst_pkg;
    localparam int DEPTH_DEFAULT = 1024;
    localparam int BANK = 16;
    localparam logic [2:0] ST_DROPPED = 3'd0;
    localparam logic [2:0] ST_COUNTED = 3'd1;
    localparam logic [2:0] ST_REFRESHED = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_READ_OK = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX = 3'd6;
    localparam logic [1:0] REG_TAG = 2'd0;
    localparam logic [1:0] REG_PRIV = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_MAX = 2'd3;
    localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture request
        logic rd_key;   // issue key read at scan address
        logic rd_ent;   // issue entry read at hit/read address
        logic wr_upd;   // write hit update
        logic wr_ins;   // append entry
        logic emit;     // build result
        logic [2:0] status;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_read;
        logic read_ok;
        logic screened_out;
        logic hit;
        logic scan_done;
        logic room;
        logic refresh;
    } sts_t;
endpackage

// ----- sv/cfst_datapath.sv -----
// Datapath: request registers, table memories, key scan and result register.
// Depends on cfst_pkg.
module cfst_datapath #(
    parameter int TABLE_DEPTH = cfst_pkg::DEPTH_DEFAULT,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = AW + 1
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfst_pkg::cmd_t cmd,
    output cfst_pkg::sts_t sts,
    input  logic cfg_tag,
    input  logic cfg_priv,
    input  logic [31:0] cfg_interval,
    input  logic [10:0] cfg_max,
    input  logic in_command,
    input  logic [31:0] in_key,
    input  logic in_valid_addr,
    input  logic in_priv,
    input  logic [31:0] in_now,
    input  logic [31:0] in_bytes,
    input  logic [31:0] in_handle,
    input  logic [9:0] in_index,
    output logic [2:0] o_status,
    output logic [9:0] o_slot,
    output logic [31:0] o_key,
    output logic [31:0] o_events,
    output logic [47:0] o_bytes,
    output logic [31:0] o_seen,
    output logic [31:0] o_sample
);
    logic [31:0] key_mem [TABLE_DEPTH];
    logic [31:0] seen_mem [TABLE_DEPTH];
    logic [31:0] samp_mem [TABLE_DEPTH];
    logic [31:0] ev_mem [TABLE_DEPTH];
    logic [47:0] by_mem [TABLE_DEPTH];
    logic [31:0] hd_mem [TABLE_DEPTH];

    logic command_reg, vaddr_reg, priv_reg;
    logic [31:0] key_reg, now_reg, bytes_reg, handle_reg;
    logic [9:0] index_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] scan_reg;       // address of key read issued
    logic chk_reg;                 // key read data valid this cycle
    logic [AW-1:0] chk_addr_reg;
    logic [31:0] key_rd_reg;
    logic hit_reg;
    logic [AW-1:0] hit_addr_reg;
    logic [31:0] e_key_reg, e_seen_reg, e_samp_reg, e_ev_reg, e_hd_reg;
    logic [47:0] e_by_reg;
    logic [AW-1:0] ent_addr;
    logic [31:0] ev_inc;
    logic [48:0] by_sum;
    logic [47:0] by_sat;
    logic [32:0] samp_lim;
    logic [CW-1:0] limit;
    logic [31:0] max_ext;
    logic [31:0] depth_ext;

    assign ent_addr = command_reg ? AW'(index_reg) : hit_addr_reg;
    assign ev_inc = (e_ev_reg == 32'hFFFF_FFFF) ? e_ev_reg : e_ev_reg + 32'd1;
    assign by_sum = {1'b0, e_by_reg} + {17'd0, bytes_reg};
    assign by_sat = by_sum[48] ? cfst_pkg::BYTES_MAX : by_sum[47:0];
    assign samp_lim = {1'b0, e_samp_reg} + {1'b0, cfg_interval};
    assign max_ext = 32'(cfg_max);
    assign depth_ext = 32'(TABLE_DEPTH);
    assign limit = (max_ext < depth_ext) ? CW'(cfg_max) : CW'(TABLE_DEPTH);

    always_comb begin
        sts.is_read = command_reg;
        sts.read_ok = {22'd0, index_reg} < 32'(fill_reg) && 32'(index_reg) < TABLE_DEPTH;
        sts.screened_out = !cfg_tag && !(vaddr_reg && (!cfg_priv || priv_reg));
        sts.hit = hit_reg;
        sts.scan_done = (scan_reg >= fill_reg) && !chk_reg;
        sts.room = fill_reg < limit;
        sts.refresh = {1'b0, now_reg} > samp_lim;
        fill_next = fill_reg + (cmd.wr_ins ? CW'(1) : CW'(0));
    end

    // Request capture, scan and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            scan_reg <= '0;
            chk_reg <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (cmd.load) begin
                command_reg <= in_command;
                key_reg <= in_key;
                vaddr_reg <= in_valid_addr;
                priv_reg <= in_priv;
                now_reg <= in_now;
                bytes_reg <= in_bytes;
                handle_reg <= in_handle;
                index_reg <= in_index;
                scan_reg <= '0;
                chk_reg <= 1'b0;
                hit_reg <= 1'b0;
            end else begin
                chk_reg <= cmd.rd_key && (scan_reg < fill_reg);
                chk_addr_reg <= scan_reg[AW-1:0];
                if (cmd.rd_key && scan_reg < fill_reg) scan_reg <= scan_reg + CW'(1);
                if (chk_reg && !hit_reg && key_rd_reg == key_reg) begin
                    hit_reg <= 1'b1;
                    hit_addr_reg <= chk_addr_reg;
                end
            end
        end
    end

    // Table memories: one write port each; one read port each, and a second one on the key memory.
    always_ff @(posedge aclk) begin
        key_rd_reg <= key_mem[scan_reg[AW-1:0]];
        if (cmd.rd_ent) begin
            e_key_reg <= key_mem[ent_addr];
            e_seen_reg <= seen_mem[ent_addr];
            e_samp_reg <= samp_mem[ent_addr];
            e_ev_reg <= ev_mem[ent_addr];
            e_by_reg <= by_mem[ent_addr];
            e_hd_reg <= hd_mem[ent_addr];
        end
        if (cmd.wr_ins) begin
            key_mem[fill_reg[AW-1:0]] <= key_reg;
            seen_mem[fill_reg[AW-1:0]] <= now_reg;
            samp_mem[fill_reg[AW-1:0]] <= now_reg;
            ev_mem[fill_reg[AW-1:0]] <= 32'd1;
            by_mem[fill_reg[AW-1:0]] <= {16'd0, bytes_reg};
            hd_mem[fill_reg[AW-1:0]] <= handle_reg;
        end else if (cmd.wr_upd) begin
            seen_mem[hit_addr_reg] <= now_reg;
            ev_mem[hit_addr_reg] <= ev_inc;
            by_mem[hit_addr_reg] <= by_sat;
            if (sts.refresh) begin
                samp_mem[hit_addr_reg] <= now_reg;
                hd_mem[hit_addr_reg] <= handle_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            o_status <= cmd.status;
            o_slot <= '0;
            o_key <= '0;
            o_events <= '0;
            o_bytes <= '0;
            o_seen <= '0;
            o_sample <= '0;
            case (cmd.status)
                cfst_pkg::ST_READ_OK: begin
                    o_slot <= 10'(ent_addr);
                    o_key <= e_key_reg;
                    o_events <= e_ev_reg;
                    o_bytes <= e_by_reg;
                    o_seen <= e_seen_reg;
                    o_sample <= e_hd_reg;
                end
                cfst_pkg::ST_COUNTED, cfst_pkg::ST_REFRESHED: begin
                    o_slot <= 10'(hit_addr_reg);
                    o_key <= e_key_reg;
                    o_events <= ev_inc;
                    o_bytes <= by_sat;
                    o_seen <= now_reg;
                    o_sample <= sts.refresh ? handle_reg : e_hd_reg;
                end
                cfst_pkg::ST_INSERTED: begin
                    o_slot <= 10'(fill_reg);
                    o_key <= key_reg;
                    o_events <= 32'd1;
                    o_bytes <= {16'd0, bytes_reg};
                    o_seen <= now_reg;
                    o_sample <= handle_reg;
                end
                cfst_pkg::ST_FULL: o_key <= key_reg;
                cfst_pkg::ST_BAD_INDEX: o_slot <= index_reg;
                default: ;
            endcase
        end
    end
endmodule

// ----- sv/cfst_ctrl.sv -----
// Controller state machine: sequences capture, scan, update and result.
// Depends on cfst_pkg.
module cfst_ctrl (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  cfst_pkg::sts_t sts,
    output cfst_pkg::cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic mval_reg, mval_next;
    logic out_free;

    assign m_valid = mval_reg;
    assign out_free = !mval_reg || m_ready;
    // Take a new request while the previous result is still held, as long as
    // it leaves before the next one is emitted.
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        mval_next = mval_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.is_read) begin
                    if (sts.read_ok) begin
                        cmd.rd_ent = 1'b1;
                        state_next = S_RDWAIT;
                    end else if (out_free) begin
                        cmd.emit = 1'b1;
                        cmd.status = cfst_pkg::ST_BAD_INDEX;
                        mval_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (sts.screened_out) begin
                    if (out_free) begin
                        cmd.emit = 1'b1;
                        cmd.status = cfst_pkg::ST_DROPPED;
                        mval_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.rd_key = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.hit) begin
                    cmd.rd_ent = 1'b1;
                    state_next = S_FETCH;
                end else if (sts.scan_done) begin
                    // hold here while the previous result is still waiting
                    if (out_free) begin
                        cmd.emit = 1'b1;
                        mval_next = 1'b1;
                        state_next = S_IDLE;
                        if (sts.room) begin
                            cmd.wr_ins = 1'b1;
                            cmd.status = cfst_pkg::ST_INSERTED;
                        end else begin
                            cmd.status = cfst_pkg::ST_FULL;
                        end
                    end
                end else begin
                    cmd.rd_key = 1'b1;
                end
            end
            S_FETCH: state_next = S_UPDATE;
            S_UPDATE: begin
                if (out_free) begin
                    cmd.wr_upd = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.status = sts.refresh ? cfst_pkg::ST_REFRESHED : cfst_pkg::ST_COUNTED;
                    mval_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RDWAIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    cmd.status = cfst_pkg::ST_READ_OK;
                    mval_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg <= mval_next;
        end
    end
endmodule

// ----- sv/client_flow_stats_table_top.sv -----
// Top level of the client flow statistics table: APB registers, controller
// and datapath. Depends on cfst_pkg, cfst_ctrl, cfst_datapath and the assert header.
//
// channel  | handshake          | payload
// s_ (in)  | s_valid / s_ready  | command, key, address flags, time, bytes, handle, index
// m_ (out) | m_valid / m_ready  | status, slot, entry fields
//
// A dropped event or a bad read index is answered from the decide step, a good read
// after its entry read. A record event scans the filled entries one key a cycle
// through a key memory read port; a miss then inserts the key or reports full,
// and a hit fetches the entry and updates it.
// Reset clears the fill count and the scan and control state and sets the APB registers to
// their defaults; the memories and the request and result registers keep no reset.
// A request is taken whenever the controller is idle; a result not yet taken holds the next request at its emit step.
`include "client_flow_stats_table_top_assert.svh"
module client_flow_stats_table_top #(
    parameter int TABLE_DEPTH = cfst_pkg::DEPTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_command,
    input  logic [31:0] s_client_key,
    input  logic s_addr_valid,
    input  logic s_addr_private,
    input  logic [31:0] s_now_seconds,
    input  logic [31:0] s_byte_count,
    input  logic [31:0] s_sample_handle,
    input  logic [9:0] s_entry_index,
    output logic m_valid,
    input  logic m_ready,
    output logic [2:0] m_status,
    output logic [9:0] m_slot,
    output logic [31:0] m_key_out,
    output logic [31:0] m_events_out,
    output logic [47:0] m_bytes_out,
    output logic [31:0] m_seen_out,
    output logic [31:0] m_sample_out
);
    logic tag_reg, priv_reg;
    logic [31:0] interval_reg;
    logic [10:0] max_reg;
    logic wr;
    cfst_pkg::cmd_t cmd;
    cfst_pkg::sts_t sts;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= 1'b0;
            priv_reg <= 1'b0;
            interval_reg <= 32'd60;
            max_reg <= 11'd1024;
        end else if (wr) begin
            case (paddr[3:2])
                cfst_pkg::REG_TAG: tag_reg <= pwdata[0];
                cfst_pkg::REG_PRIV: priv_reg <= pwdata[0];
                cfst_pkg::REG_INTERVAL: interval_reg <= pwdata;
                cfst_pkg::REG_MAX: max_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cfst_pkg::REG_TAG: prdata = {31'd0, tag_reg};
            cfst_pkg::REG_PRIV: prdata = {31'd0, priv_reg};
            cfst_pkg::REG_INTERVAL: prdata = interval_reg;
            cfst_pkg::REG_MAX: prdata = {21'd0, max_reg};
            default: prdata = '0;
        endcase
    end

    cfst_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    cfst_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_tag(tag_reg), .cfg_priv(priv_reg),
        .cfg_interval(interval_reg), .cfg_max(max_reg),
        .in_command(s_command), .in_key(s_client_key),
        .in_valid_addr(s_addr_valid), .in_priv(s_addr_private),
        .in_now(s_now_seconds), .in_bytes(s_byte_count),
        .in_handle(s_sample_handle), .in_index(s_entry_index),
        .o_status(m_status), .o_slot(m_slot), .o_key(m_key_out),
        .o_events(m_events_out), .o_bytes(m_bytes_out),
        .o_seen(m_seen_out), .o_sample(m_sample_out)
    );

    `CFST_ASSERT_CLK(a_one_cmd, !(cmd.wr_ins && cmd.wr_upd), "insert and update together")
    `CFST_ASSERT_NEXT(a_emit_valid, cmd.emit, m_valid, "result emitted without valid")
    `CFST_ASSERT_CLK(a_no_emit_busy, !(cmd.emit && m_valid && !m_ready), "result over held result")
endmodule
